// ----- design/tcpdm_pkg.sv -----
// package for the three channel phase difference meter: widths, codes and reset values
`timescale 1ns / 1ps
package tcpdm_pkg;

    // field and register widths
    localparam int unsigned MAX_W      = 12;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned PINS_W     = 6;
    localparam int unsigned APB_AW     = 3;
    localparam int unsigned APB_DW     = 32;

    // defaults
    localparam int unsigned CHANNELS_DEF  = 3;
    localparam int unsigned REPORTED      = 3;
    localparam logic [MAX_W-1:0] MAX_COUNT_RST = 12'd495;

    // register indexes (word address bit above the byte offset)
    localparam logic REG_MAX_COUNT = 1'b0;

    // input action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // per channel measurement modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_PLUS  = 2'd2;
    localparam logic [1:0] MODE_MINUS = 2'd3;

    // pin patterns of one channel
    localparam logic [1:0] PINS_NONE = 2'd0;
    localparam logic [1:0] PINS_LOW  = 2'd1;
    localparam logic [1:0] PINS_HIGH = 2'd2;
    localparam logic [1:0] PINS_BOTH = 2'd3;

    // duty codes
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 8'd127;
    localparam logic [DUTY_W-1:0] DUTY_MIN  = 8'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'd255;

endpackage

// ----- design/three_channel_phase_difference_meter.sv -----
// top level of the three channel phase difference meter
`timescale 1ns / 1ps
// Phase difference meter for up to CHANNELS pin pairs, three of them reported.
// Input channel (s_valid/s_ready): one beat is either a timer tick (s_action 0)
// or a sample of the six pin levels (s_action 1, s_pins).
// Result channel (m_valid/m_ready): one beat per input beat carrying the duty
// and the latched signed tick difference of channels A, B and C.
// max_count is written over the APB port at byte address 0; the user must write
// it only while idle; the block itself does not enforce this.
// Each channel goes through the update state, followed by the shared restoring
// divider when its duty is recomputed and does not saturate, and the result
// register is loaded at the end. s_ready is low while an item is being worked
// on, so no new beat is taken before the previous one has left the sequencer.
// The result register sits between the sides: a new beat is accepted while
// the previous result still waits, and if the receiver stalls the next result
// holds in the sequencer until the register frees up.
// Reset (aresetn low, synchronous) puts all channels in START with zero counts,
// duty 127, max_count 495, and empties the result register.
module three_channel_phase_difference_meter #(
    parameter int unsigned CHANNELS = tcpdm_pkg::CHANNELS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // apb configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tcpdm_pkg::APB_AW-1:0]           paddr,
    input  logic [tcpdm_pkg::APB_DW-1:0]           pwdata,
    output logic [tcpdm_pkg::APB_DW-1:0]           prdata,
    output logic                                   pready,
    // input beats
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [tcpdm_pkg::PINS_W-1:0]           s_pins,
    // result beats
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [tcpdm_pkg::DUTY_W-1:0]           m_duty_a,
    output logic [tcpdm_pkg::DUTY_W-1:0]           m_duty_b,
    output logic [tcpdm_pkg::DUTY_W-1:0]           m_duty_c,
    output logic signed [tcpdm_pkg::CNT_W-1:0]     m_diff_a,
    output logic signed [tcpdm_pkg::CNT_W-1:0]     m_diff_b,
    output logic signed [tcpdm_pkg::CNT_W-1:0]     m_diff_c
);
    import tcpdm_pkg::*;

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // clamp a count to plus or minus the limit
    function automatic logic signed [CNT_W-1:0] clamp_cnt(
        input logic signed [CNT_W:0] v,
        input logic [MAX_W-1:0]      lim
    );
        logic signed [CNT_W:0] hi;
        logic signed [CNT_W:0] lo;
        logic signed [CNT_W:0] r;
        begin
            hi = signed'({2'b00, lim});
            lo = -hi;
            if (v > hi) begin
                r = hi;
            end else if (v < lo) begin
                r = lo;
            end else begin
                r = v;
            end
            return r[CNT_W-1:0];
        end
    endfunction

    // configuration
    logic [MAX_W-1:0] max_reg;

    // per channel state
    logic [1:0]              mode_reg    [CHANNELS];
    logic [1:0]              prev_reg    [CHANNELS];
    logic signed [CNT_W-1:0] count_reg   [CHANNELS];
    logic signed [CNT_W-1:0] latched_reg [CHANNELS];
    logic [DUTY_W-1:0]       duty_reg    [CHANNELS];

    // sequencer and divider
    logic [1:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              action_reg;
    logic [PINS_W-1:0] pins_reg;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DUTY_W-1:0] quo_reg, quo_next;
    logic [2:0]        step_reg, step_next;

    // result register
    logic                    m_valid_reg;
    logic [DUTY_W-1:0]       duty_out_reg [REPORTED];
    logic signed [CNT_W-1:0] diff_out_reg [REPORTED];
    logic [DUTY_W-1:0]       res_duty [REPORTED];
    logic signed [CNT_W-1:0] res_diff [REPORTED];

    // apb port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_COUNT);
    assign prdata = (paddr[2] == REG_MAX_COUNT) ? {{(APB_DW-MAX_W){1'b0}}, max_reg}
                                                : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_COUNT_RST;
        end else if (cfg_wr) begin
            max_reg <= pwdata[MAX_W-1:0];
        end
    end

    // pin pair of the channel under work; channels beyond C see zero
    logic [3:0] ch_ext;
    logic [1:0] chan_pins;
    assign ch_ext = 4'(ch_reg);
    always_comb begin
        case (ch_ext)
            4'd0:    chan_pins = pins_reg[1:0];
            4'd1:    chan_pins = pins_reg[3:2];
            4'd2:    chan_pins = pins_reg[5:4];
            default: chan_pins = PINS_NONE;
        endcase
    end

    // channel update for a tick or a pin sample
    logic [1:0]              cur_mode, new_mode, new_prev;
    logic signed [CNT_W-1:0] cur_count, new_count, new_latched, cur_latched;
    logic signed [CNT_W:0]   count_wide;
    always_comb begin
        cur_mode    = mode_reg[ch_reg];
        cur_count   = count_reg[ch_reg];
        cur_latched = latched_reg[ch_reg];
        count_wide  = {cur_count[CNT_W-1], cur_count};
        new_mode    = cur_mode;
        new_prev    = prev_reg[ch_reg];
        new_count   = cur_count;
        new_latched = cur_latched;
        if (action_reg == ACT_TICK) begin
            if (cur_mode == MODE_PLUS) begin
                new_count = clamp_cnt(count_wide + 14'sd1, max_reg);
            end else if (cur_mode == MODE_MINUS) begin
                new_count = clamp_cnt(count_wide - 14'sd1, max_reg);
            end
        end else if (cur_mode == MODE_START) begin
            if (chan_pins == PINS_NONE) begin
                new_mode = MODE_WAIT;
                new_prev = PINS_NONE;
            end
        end else if (chan_pins != prev_reg[ch_reg]) begin
            new_prev = chan_pins;
            if (cur_mode == MODE_WAIT) begin
                new_count   = '0;
                new_latched = '0;
                case (chan_pins)
                    PINS_LOW:  new_mode = MODE_MINUS;
                    PINS_HIGH: new_mode = MODE_PLUS;
                    default:   new_mode = MODE_START;
                endcase
            end else begin
                new_mode = MODE_START;
                if (chan_pins == PINS_BOTH) begin
                    new_count   = clamp_cnt(count_wide, max_reg);
                    new_latched = new_count;
                end else begin
                    new_count   = '0;
                    new_latched = '0;
                end
            end
        end
    end

    // duty numerator and divisor
    logic signed [CNT_W:0] duty_num;
    logic [CNT_W-1:0]      den;
    logic                  duty_due;
    assign duty_num = {new_latched[CNT_W-1], new_latched} + signed'({2'b00, max_reg});
    assign den      = {max_reg, 1'b0};
    assign duty_due = (new_mode == MODE_START) || (new_mode == MODE_WAIT);

    // one restoring divider step
    logic [CNT_W:0] rem_dbl;
    logic           rem_fits;
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_fits = rem_dbl >= {1'b0, den};

    // sequencer
    logic              ch_write;
    logic              duty_write;
    logic [DUTY_W-1:0] duty_wdata;
    logic              out_load;
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        ch_write   = 1'b0;
        duty_write = 1'b0;
        duty_wdata = DUTY_ZERO;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPD;
                    ch_next    = '0;
                end
            end
            ST_UPD: begin
                ch_write = 1'b1;
                if (duty_due && (max_reg != '0) && (duty_num > 14'sd0)
                        && !(new_latched >= signed'({1'b0, max_reg}))) begin
                    // quotient below 256: run the divider
                    rem_next   = duty_num[CNT_W-1:0];
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    if (duty_due) begin
                        duty_write = 1'b1;
                        if (max_reg == '0) begin
                            duty_wdata = DUTY_ZERO;
                        end else if (duty_num <= 14'sd0) begin
                            duty_wdata = DUTY_MIN;
                        end else begin
                            duty_wdata = DUTY_MAX;
                        end
                    end
                    if (ch_reg == LAST_CH) begin
                        state_next = ST_DONE;
                    end else begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = rem_fits ? CNT_W'(rem_dbl - {1'b0, den}) : rem_dbl[CNT_W-1:0];
                quo_next  = {quo_reg[DUTY_W-2:0], rem_fits};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    duty_write = 1'b1;
                    duty_wdata = quo_next;
                    if (ch_reg == LAST_CH) begin
                        state_next = ST_DONE;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // captured beat and divider datapath
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            pins_reg   <= s_pins;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    // channel state storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                mode_reg[i]    <= MODE_START;
                prev_reg[i]    <= PINS_NONE;
                count_reg[i]   <= '0;
                latched_reg[i] <= '0;
                duty_reg[i]    <= DUTY_ZERO;
            end
        end else begin
            if (ch_write) begin
                mode_reg[ch_reg]    <= new_mode;
                prev_reg[ch_reg]    <= new_prev;
                count_reg[ch_reg]   <= new_count;
                latched_reg[ch_reg] <= new_latched;
            end
            if (duty_write) begin
                duty_reg[ch_reg] <= duty_wdata;
            end
        end
    end

    // reported channels; missing ones read as idle
    for (genvar g = 0; g < REPORTED; g++) begin : g_report
        if (g < CHANNELS) begin : g_real
            assign res_duty[g] = duty_reg[g];
            assign res_diff[g] = latched_reg[g];
        end else begin : g_none
            assign res_duty[g] = DUTY_ZERO;
            assign res_diff[g] = '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < REPORTED; i++) begin
                duty_out_reg[i] <= res_duty[i];
                diff_out_reg[i] <= res_diff[i];
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_duty_a = duty_out_reg[0];
    assign m_duty_b = duty_out_reg[1];
    assign m_duty_c = duty_out_reg[2];
    assign m_diff_a = diff_out_reg[0];
    assign m_diff_b = diff_out_reg[1];
    assign m_diff_c = diff_out_reg[2];

`ifndef SYNTHESIS
    // no second beat is taken right after one is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in work");

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den))
        else $error("divider remainder out of range");

    // the channel pointer never passes the last channel while working
    a_ch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_UPD) || (state_reg == ST_DIV)) |-> (ch_reg <= LAST_CH))
        else $error("channel pointer out of range");

    // a result is loaded only when the result register is free or drains
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result register overwritten while stalled");
`endif

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the three channel phase difference meter
`timescale 1ns / 1ps
module tb_top;
    import tcpdm_pkg::*;

    localparam int CH = REPORTED;
    localparam int IDLE_PCT = 26;
    localparam int RANDOM_ITEMS = 750;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [APB_AW-1:0] MAX_COUNT_ADDR = {REG_MAX_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_MAX_COUNT, 2'b00};

    typedef struct {
        logic              action;
        logic [PINS_W-1:0] pins;
    } pin_beat_t;

    typedef struct {
        logic [DUTY_W-1:0]       duty [CH];
        logic signed [CNT_W-1:0] diff [CH];
    } meter_reading_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = ACT_TICK;
    logic [PINS_W-1:0] s_pins = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DUTY_W-1:0] m_duty_a, m_duty_b, m_duty_c;
    logic signed [CNT_W-1:0] m_diff_a, m_diff_b, m_diff_c;

    // predictor copy of the channel state and the register
    logic [1:0]       ch_mode [CH];
    logic [1:0]       ch_prev [CH];
    int               ch_count [CH];
    int               ch_latch [CH];
    logic [DUTY_W-1:0] ch_duty [CH];
    logic [MAX_W-1:0] cur_max;

    pin_beat_t      pending_beats [$];
    meter_reading_t reading_q [$];
    int queued_cnt = 0;
    int taken_cnt = 0;
    int fail_cnt = 0;
    logic calm = 1'b0;

    three_channel_phase_difference_meter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_pins   (s_pins),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_duty_a (m_duty_a),
        .m_duty_b (m_duty_b),
        .m_duty_c (m_duty_c),
        .m_diff_a (m_diff_a),
        .m_diff_b (m_diff_b),
        .m_diff_c (m_diff_c)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic note_fail(string what, int exp_v, int act_v);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, act_v);
        end
    endtask

    function automatic int clamp_to(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // duty from the latched difference, saturating at both ends
    function automatic logic [DUTY_W-1:0] duty_of(int lat, logic [MAX_W-1:0] lim);
        longint l;
        longint num;
        longint q;
        l = lim;
        if (l == 0) return DUTY_ZERO;
        num = (longint'(lat) + l) * 256;
        if (num <= 0) return DUTY_MIN;
        q = num / (2 * l);
        if (q > 255) return DUTY_MAX;
        return q[DUTY_W-1:0];
    endfunction

    // advance all channels by one accepted beat and queue the expected reading
    task automatic advance_meter(logic act, logic [PINS_W-1:0] pins);
        meter_reading_t want;
        logic [1:0] p;
        int lim;
        lim = cur_max;
        for (int i = 0; i < CH; i++) begin
            p = pins[2*i +: 2];
            if (act == ACT_TICK) begin
                if (ch_mode[i] == MODE_PLUS) begin
                    ch_count[i] = clamp_to(ch_count[i] + 1, lim);
                end else if (ch_mode[i] == MODE_MINUS) begin
                    ch_count[i] = clamp_to(ch_count[i] - 1, lim);
                end
            end else if (ch_mode[i] == MODE_START) begin
                if (p == PINS_NONE) begin
                    ch_mode[i] = MODE_WAIT;
                    ch_prev[i] = PINS_NONE;
                end
            end else if (p != ch_prev[i]) begin
                if (ch_mode[i] == MODE_WAIT) begin
                    ch_count[i] = 0;
                    ch_latch[i] = 0;
                    case (p)
                        PINS_LOW: begin
                            ch_mode[i] = MODE_MINUS;
                        end
                        PINS_HIGH: begin
                            ch_mode[i] = MODE_PLUS;
                        end
                        default: begin
                            ch_mode[i] = MODE_START;
                        end
                    endcase
                end else begin
                    // both pins high ends the measurement, anything else aborts it
                    ch_mode[i] = MODE_START;
                    if (p == PINS_BOTH) begin
                        ch_count[i] = clamp_to(ch_count[i], lim);
                        ch_latch[i] = ch_count[i];
                    end else begin
                        ch_count[i] = 0;
                        ch_latch[i] = 0;
                    end
                end
                ch_prev[i] = p;
            end
            if (ch_mode[i] == MODE_START || ch_mode[i] == MODE_WAIT) begin
                ch_duty[i] = duty_of(ch_latch[i], cur_max);
            end
            want.duty[i] = ch_duty[i];
            want.diff[i] = CNT_W'(ch_latch[i]);
        end
        reading_q.push_back(want);
    endtask

    // input driver
    always @(posedge aclk) begin : beat_driver
        pin_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_meter(s_action, s_pins);
                taken_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() > 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_action <= nxt.action;
                    s_pins <= nxt.pins;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : reading_monitor
        meter_reading_t want;
        logic [DUTY_W-1:0] got_duty [CH];
        logic signed [CNT_W-1:0] got_diff [CH];
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                got_duty[0] = m_duty_a;
                got_duty[1] = m_duty_b;
                got_duty[2] = m_duty_c;
                got_diff[0] = m_diff_a;
                got_diff[1] = m_diff_b;
                got_diff[2] = m_diff_c;
                if (reading_q.size() == 0) begin
                    note_fail("result beat with nothing pending", 0, 1);
                end else begin
                    want = reading_q.pop_front();
                    for (int i = 0; i < CH; i++) begin
                        if (got_duty[i] !== want.duty[i]) begin
                            note_fail($sformatf("duty of channel %0d", i),
                                      want.duty[i], got_duty[i]);
                        end
                        if (got_diff[i] !== want.diff[i]) begin
                            note_fail($sformatf("diff of channel %0d", i),
                                      int'(want.diff[i]), int'(got_diff[i]));
                        end
                    end
                end
            end
        end
    end

    task automatic add_beat(logic act, logic [PINS_W-1:0] pins);
        pin_beat_t b;
        b.action = act;
        b.pins = pins;
        pending_beats.push_back(b);
        queued_cnt++;
    endtask

    // one measurement: all pins low, then per channel a first edge and a
    // both-high edge at random ticks, sometimes with a glitch on one channel
    task automatic add_measurement();
        int t_first [CH];
        int t_second [CH];
        int pin_first [CH];
        int span;
        int cap;
        int t_break;
        int bc;
        logic [PINS_W-1:0] lv;
        logic [PINS_W-1:0] nxt;
        cap = (cur_max < 20) ? 2 * cur_max + 3 : 30;
        span = $urandom_range(cap, 1);
        t_break = ($urandom_range(99) < 20) ? $urandom_range(span, 0) : -1;
        bc = $urandom_range(CH - 1, 0);
        lv = '0;
        add_beat(ACT_SAMPLE, lv);
        for (int c = 0; c < CH; c++) begin
            t_first[c] = $urandom_range(span, 0);
            t_second[c] = $urandom_range(span, t_first[c]);
            pin_first[c] = $urandom_range(1, 0);
        end
        for (int t = 0; t <= span; t++) begin
            nxt = lv;
            for (int c = 0; c < CH; c++) begin
                if (t == t_first[c]) nxt[2*c + pin_first[c]] = 1'b1;
                if (t == t_second[c]) nxt[2*c +: 2] = PINS_BOTH;
            end
            if (t == t_break) nxt[2*bc +: 2] = 2'($urandom);
            if (nxt != lv) add_beat(ACT_SAMPLE, nxt);
            lv = nxt;
            if (t < span) add_beat(ACT_TICK, PINS_W'($urandom));
        end
    endtask

    // wait until every beat is taken and every reading has come back
    task automatic settle();
        while (taken_cnt != queued_cnt || reading_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [MAX_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {20'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == MAX_COUNT_ADDR) cur_max = value;
    endtask

    task automatic reg_check();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MAX_COUNT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata[MAX_W-1:0] !== cur_max) begin
            note_fail("max_count read back", cur_max, prdata[MAX_W-1:0]);
        end
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // watchdog
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int start_cnt;
        int goal;
        int phase;
        int roll;
        for (int i = 0; i < CH; i++) begin
            ch_mode[i] = MODE_START;
            ch_prev[i] = PINS_NONE;
            ch_count[i] = 0;
            ch_latch[i] = 0;
            ch_duty[i] = DUTY_ZERO;
        end
        cur_max = MAX_COUNT_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        reg_check();

        // reset limit: A and C count down, B up, then all latch
        add_beat(ACT_SAMPLE, 6'b000000);
        add_beat(ACT_SAMPLE, 6'b011001);
        add_beat(ACT_TICK, 6'b111111);
        add_beat(ACT_TICK, 6'b000000);
        add_beat(ACT_SAMPLE, 6'b111111);
        add_beat(ACT_SAMPLE, 6'b000000);
        settle();

        // write outside the register map is ignored
        reg_write(SPARE_ADDR, 12'd7);
        reg_check();

        // limit of one: saturated counts give the top and bottom duty
        reg_write(MAX_COUNT_ADDR, 12'd1);
        add_beat(ACT_SAMPLE, 6'b100110);
        add_beat(ACT_TICK, 6'b010101);
        add_beat(ACT_TICK, 6'b101010);
        add_beat(ACT_SAMPLE, 6'b111111);
        add_beat(ACT_SAMPLE, 6'b000000);
        settle();

        // A and B latch at -5 and +5, C keeps counting up
        reg_write(MAX_COUNT_ADDR, 12'd8);
        add_beat(ACT_SAMPLE, 6'b101001);
        repeat (5) add_beat(ACT_TICK, 6'b000000);
        add_beat(ACT_SAMPLE, 6'b101111);
        settle();

        // shrink the limit: negative duty numerator on A, C clamps on its next tick
        reg_write(MAX_COUNT_ADDR, 12'd2);
        add_beat(ACT_TICK, 6'b000000);
        add_beat(ACT_SAMPLE, 6'b111111);
        add_beat(ACT_SAMPLE, 6'b000000);
        settle();

        // zero limit: counts stay at zero, duty rests at the midpoint
        reg_write(MAX_COUNT_ADDR, 12'd0);
        reg_check();
        add_beat(ACT_SAMPLE, 6'b011001);
        add_beat(ACT_TICK, 6'b000000);
        add_beat(ACT_SAMPLE, 6'b111111);
        settle();

        // random phases over several limits, one of them without idling
        start_cnt = queued_cnt;
        phase = 0;
        while (queued_cnt - start_cnt < RANDOM_ITEMS) begin
            case (phase % 5)
                0: reg_write(MAX_COUNT_ADDR, 12'($urandom_range(12, 1)));
                1: reg_write(MAX_COUNT_ADDR, 12'd4095);
                2: reg_write(MAX_COUNT_ADDR, 12'($urandom_range(4095, 1)));
                3: reg_write(MAX_COUNT_ADDR, 12'd1);
                default: reg_write(MAX_COUNT_ADDR, 12'($urandom_range(60, 13)));
            endcase
            if (phase < 5) reg_check();
            calm = (phase == 3);
            goal = queued_cnt + 100;
            while (queued_cnt < goal) begin
                roll = $urandom_range(99);
                if (roll < 75) begin
                    add_measurement();
                end else if (roll < 90) begin
                    add_beat(ACT_SAMPLE, PINS_W'($urandom));
                end else begin
                    add_beat(ACT_TICK, PINS_W'($urandom));
                end
            end
            settle();
            calm = 1'b0;
            phase++;
        end

        if (reading_q.size() != 0) begin
            note_fail("readings never delivered", 0, reading_q.size());
        end
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
